// ===== hdl/hslp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslp_pkg
// Shared types and constants of the handheld serial link port.
// ----------------------------------------------------------------------------
package hslp_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned APB_W   = 32;

    localparam logic [COUNT_W-1:0] XFER_CYCLES_RST = 16'd4096;
    localparam logic [BYTE_W-1:0]  CTRL_START_BIT  = 8'h80;
    localparam logic [BYTE_W-1:0]  CTRL_CLOCK_BIT  = 8'h01;
    localparam logic [BYTE_W-1:0]  CTRL_DONE_MASK  = 8'h7F;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_DATA = 3'd0,
        CMD_WR_CTRL = 3'd1,
        CMD_PULLED  = 3'd2,
        CMD_PUSHED  = 3'd3,
        CMD_TICK    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PRESENT = 2'd1,
        MODE_XFER    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESENT = 2'd1,
        EV_PUSH    = 2'd2
    } t_link_ev;

    // register map, word index
    typedef enum logic [0:0] {
        REG_XFER_CYCLES = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] byte_in;
        logic [BYTE_W-1:0] tick_cycles;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data_reg;
        logic [BYTE_W-1:0] control_reg;
        t_link_ev          link_event;
        logic [BYTE_W-1:0] link_byte;
        logic              irq;
    } t_result;

endpackage

// ===== hdl/hslp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslp_in_if / hslp_out_if
// Valid/ready channels carrying command beats in and result beats out.
// ----------------------------------------------------------------------------
interface hslp_in_if;
    logic                         valid;
    logic                         ready;
    logic [hslp_pkg::CMD_W-1:0]   cmd;
    logic [hslp_pkg::BYTE_W-1:0]  byte_in;
    logic [hslp_pkg::BYTE_W-1:0]  tick_cycles;

    modport source (output valid, output cmd, output byte_in, output tick_cycles,
                    input ready);
    modport sink   (input valid, input cmd, input byte_in, input tick_cycles,
                    output ready);
endinterface

interface hslp_out_if;
    logic                         valid;
    logic                         ready;
    logic [hslp_pkg::BYTE_W-1:0]  data_reg;
    logic [hslp_pkg::BYTE_W-1:0]  control_reg;
    logic [1:0]                   link_event;
    logic [hslp_pkg::BYTE_W-1:0]  link_byte;
    logic                         irq;

    modport source (output valid, output data_reg, output control_reg,
                    output link_event, output link_byte, output irq, input ready);
    modport sink   (input valid, input data_reg, input control_reg,
                    input link_event, input link_byte, input irq, output ready);
endinterface

// ===== hdl/handheld_serial_link_port.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_serial_link_port
// Serial link port with data and control bytes, partner byte handling and a
// cycle countdown for internally clocked transfers. Each command beat gives
// exactly one result beat. The port takes one beat every cycle while the
// result channel does not stall: a beat is captured in an input register,
// then the port state and the result are updated together and the result
// waits in an output register. Backpressure on the result channel holds
// the input register and then the command channel. The transfer cycle
// count sits in the APB register at byte address 0 and should only be
// written while no beat is in flight.
// ----------------------------------------------------------------------------
module handheld_serial_link_port (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [hslp_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [hslp_pkg::APB_W-1:0]     i_pwdata,
    output logic [hslp_pkg::APB_W-1:0]     o_prdata,
    output logic                           o_pready,
    hslp_in_if.sink                        i_in,
    hslp_out_if.source                     o_out
);

    logic [hslp_pkg::COUNT_W-1:0] w_xfer_cycles;

    hslp_apb u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (i_psel),
        .i_penable     (i_penable),
        .i_pwrite      (i_pwrite),
        .i_paddr       (i_paddr),
        .i_pwdata      (i_pwdata),
        .o_prdata      (o_prdata),
        .o_pready      (o_pready),
        .o_xfer_cycles (w_xfer_cycles)
    );

    hslp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_xfer_cycles (w_xfer_cycles),
        .i_in          (i_in),
        .o_out         (o_out)
    );

endmodule

// ===== hdl/hslp_apb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslp_apb
// APB register slave holding the transfer cycle count.
// ----------------------------------------------------------------------------
module hslp_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [hslp_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [hslp_pkg::APB_W-1:0]     i_pwdata,
    output logic [hslp_pkg::APB_W-1:0]     o_prdata,
    output logic                           o_pready,
    output logic [hslp_pkg::COUNT_W-1:0]   o_xfer_cycles
);

    logic [hslp_pkg::COUNT_W-1:0] r_xfer_cycles;
    logic                         w_sel_xfer;
    logic                         w_wr;

    assign o_pready   = 1'b1;
    assign w_sel_xfer = (i_paddr[hslp_pkg::ADDR_W-1] == hslp_pkg::REG_XFER_CYCLES);
    assign w_wr       = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xfer_cycles <= hslp_pkg::XFER_CYCLES_RST;
        end else if (w_wr && w_sel_xfer) begin
            r_xfer_cycles <= i_pwdata[hslp_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (w_sel_xfer) begin
            o_prdata = {{(hslp_pkg::APB_W-hslp_pkg::COUNT_W){1'b0}}, r_xfer_cycles};
        end
    end

    assign o_xfer_cycles = r_xfer_cycles;

endmodule

// ===== hdl/hslp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslp_core
// Input register, serial port state update and result register.
// ----------------------------------------------------------------------------
module hslp_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [hslp_pkg::COUNT_W-1:0]   i_xfer_cycles,
    hslp_in_if.sink                        i_in,
    hslp_out_if.source                     o_out
);

    // pipeline
    logic               r_in_valid;
    hslp_pkg::t_item    r_in;
    logic               r_out_valid;
    hslp_pkg::t_result  r_out;
    logic               w_adv;

    // port state
    hslp_pkg::t_mode                r_mode;
    logic [hslp_pkg::BYTE_W-1:0]    r_data;
    logic [hslp_pkg::BYTE_W-1:0]    r_ctrl;
    logic [hslp_pkg::COUNT_W-1:0]   r_count;
    logic [hslp_pkg::BYTE_W-1:0]    r_held;
    logic                           r_held_valid;

    hslp_pkg::t_mode                n_mode;
    logic [hslp_pkg::BYTE_W-1:0]    n_data;
    logic [hslp_pkg::BYTE_W-1:0]    n_ctrl;
    logic [hslp_pkg::COUNT_W-1:0]   n_count;
    logic [hslp_pkg::BYTE_W-1:0]    n_held;
    logic                           n_held_valid;
    hslp_pkg::t_result              n_out;

    hslp_pkg::t_mode                w_target;
    logic                           w_enter;
    logic                           w_complete;
    logic [hslp_pkg::COUNT_W-1:0]   w_cyc;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.cmd         <= i_in.cmd;
            r_in.byte_in     <= i_in.byte_in;
            r_in.tick_cycles <= i_in.tick_cycles;
        end
    end

    // decode of the registered beat
    always_comb begin
        w_cyc = {{(hslp_pkg::COUNT_W-hslp_pkg::BYTE_W){1'b0}}, r_in.tick_cycles};
        if ((r_in.byte_in & hslp_pkg::CTRL_START_BIT) == '0) begin
            w_target = hslp_pkg::MODE_IDLE;
        end else if ((r_in.byte_in & hslp_pkg::CTRL_CLOCK_BIT) != '0) begin
            w_target = hslp_pkg::MODE_XFER;
        end else begin
            w_target = hslp_pkg::MODE_PRESENT;
        end
        w_enter = (r_in.cmd == hslp_pkg::CMD_WR_CTRL) && (r_in.byte_in != r_ctrl)
                  && (w_target != r_mode);
        case (r_in.cmd)
            hslp_pkg::CMD_PULLED: begin
                w_complete = (r_mode == hslp_pkg::MODE_XFER) && (r_count == '0);
            end
            hslp_pkg::CMD_PUSHED: begin
                w_complete = (r_mode == hslp_pkg::MODE_PRESENT);
            end
            hslp_pkg::CMD_TICK: begin
                w_complete = (r_mode == hslp_pkg::MODE_XFER) && (r_count <= w_cyc)
                             && r_held_valid;
            end
            default: begin
                w_complete = 1'b0;
            end
        endcase
    end

    // next mode
    always_comb begin
        if (w_complete) begin
            n_mode = hslp_pkg::MODE_IDLE;
        end else if (w_enter) begin
            n_mode = w_target;
        end else begin
            n_mode = r_mode;
        end
    end

    // register updates and result fields
    always_comb begin
        n_data       = r_data;
        n_ctrl       = r_ctrl;
        n_count      = r_count;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_out.link_event = hslp_pkg::EV_NONE;
        n_out.link_byte  = '0;
        case (r_in.cmd)
            hslp_pkg::CMD_WR_DATA: begin
                n_data = r_in.byte_in;
                if (r_in.byte_in != r_data && r_mode == hslp_pkg::MODE_PRESENT) begin
                    n_out.link_event = hslp_pkg::EV_PRESENT;
                    n_out.link_byte  = r_in.byte_in;
                end
            end
            hslp_pkg::CMD_WR_CTRL: begin
                n_ctrl = r_in.byte_in;
                if (w_enter && w_target == hslp_pkg::MODE_PRESENT) begin
                    n_out.link_event = hslp_pkg::EV_PRESENT;
                    n_out.link_byte  = r_data;
                end else if (w_enter && w_target == hslp_pkg::MODE_XFER) begin
                    n_out.link_event = hslp_pkg::EV_PUSH;
                    n_out.link_byte  = r_data;
                    n_count          = i_xfer_cycles;
                end
            end
            hslp_pkg::CMD_PULLED, hslp_pkg::CMD_PUSHED: begin
                n_held       = r_in.byte_in;
                n_held_valid = 1'b1;
            end
            hslp_pkg::CMD_TICK: begin
                if (r_mode == hslp_pkg::MODE_XFER) begin
                    n_count = (r_count > w_cyc) ? (r_count - w_cyc) : '0;
                end
            end
            default: begin
            end
        endcase
        if (w_complete) begin
            n_held_valid = 1'b0;
            n_ctrl       = n_ctrl & hslp_pkg::CTRL_DONE_MASK;
            n_data       = n_held;
        end
        n_out.data_reg    = n_data;
        n_out.control_reg = n_ctrl;
        n_out.irq         = w_complete;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= hslp_pkg::MODE_IDLE;
            r_data       <= '0;
            r_ctrl       <= '0;
            r_count      <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
        end else if (w_adv) begin
            r_mode       <= n_mode;
            r_data       <= n_data;
            r_ctrl       <= n_ctrl;
            r_count      <= n_count;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.data_reg    = r_out.data_reg;
    assign o_out.control_reg = r_out.control_reg;
    assign o_out.link_event  = r_out.link_event;
    assign o_out.link_byte   = r_out.link_byte;
    assign o_out.irq         = r_out.irq;

    // a waiting result always reflects the current port state
    a_data_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.data_reg == r_data && r_out.control_reg == r_ctrl))
        else $error("result beat out of step with port state");

    a_irq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.irq) |->
            (r_mode == hslp_pkg::MODE_IDLE && !r_out.control_reg[7] && !r_held_valid))
        else $error("completion did not return port to idle");

    a_push_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.link_event == hslp_pkg::EV_PUSH) |->
            (r_mode == hslp_pkg::MODE_XFER && r_count == i_xfer_cycles))
        else $error("push without entering transfer");

    a_no_event_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.link_event == hslp_pkg::EV_NONE) |-> (r_out.link_byte == '0))
        else $error("link byte set without link event");

endmodule

// ===== bench/handheld_serial_link_port_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_serial_link_port_test
// Self-checking bench for the serial link port. A short table of commands
// covers the edge cases first, then random transfer sequences run under
// several transfer cycle settings. Each command beat is predicted at
// acceptance and the result beats are compared in order, field by field.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module handheld_serial_link_port_test;

    // command codes the port must ignore
    localparam logic [hslp_pkg::CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [hslp_pkg::CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 205;
    localparam int NUM_PHASES   = 6;

    typedef struct packed {
        logic                        is_cfg;
        logic [15:0]                 cfg_val;
        logic [hslp_pkg::CMD_W-1:0]  cmd;
        logic [hslp_pkg::BYTE_W-1:0] byte_in;
        logic [hslp_pkg::BYTE_W-1:0] cyc;
        logic                        typed;
        hslp_pkg::t_result           exp;
    } t_dir_row;

    localparam hslp_pkg::t_result RES_ZERO = '0;

    localparam int DIR_N = 31;
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        '{1'b0, 16'h0000, hslp_pkg::CMD_TICK,    8'hFF, 8'hFF, 1'b1, RES_ZERO},
        '{1'b0, 16'h0000, CMD_RSVD_LO,           8'hFF, 8'hFF, 1'b1, RES_ZERO},
        '{1'b0, 16'h0000, CMD_RSVD_HI,           8'h00, 8'h00, 1'b1, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_DATA, 8'hA5, 8'h00, 1'b1,
          '{8'hA5, 8'h00, hslp_pkg::EV_NONE, 8'h00, 1'b0}},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_CTRL, 8'h80, 8'h00, 1'b1,
          '{8'hA5, 8'h80, hslp_pkg::EV_PRESENT, 8'hA5, 1'b0}},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_DATA, 8'h5A, 8'hFF, 1'b1,
          '{8'h5A, 8'h80, hslp_pkg::EV_PRESENT, 8'h5A, 1'b0}},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_DATA, 8'h5A, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_CTRL, 8'h80, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_CTRL, 8'h82, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_PULLED,  8'h33, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_PUSHED,  8'hFF, 8'h00, 1'b1,
          '{8'hFF, 8'h02, hslp_pkg::EV_NONE, 8'h00, 1'b1}},
        '{1'b0, 16'h0000, hslp_pkg::CMD_PULLED,  8'h00, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_PUSHED,  8'h44, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_CTRL, 8'h81, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_DATA, 8'hC3, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_TICK,    8'h00, 8'hFF, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_PULLED,  8'h3C, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_CTRL, 8'h00, 8'h00, 1'b0, RES_ZERO},
        // zero transfer cycles, the pulled byte completes on the pull
        '{1'b1, 16'h0000, hslp_pkg::CMD_WR_DATA, 8'h00, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_CTRL, 8'h81, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_PULLED,  8'h77, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_CTRL, 8'h81, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_TICK,    8'h00, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_PULLED,  8'h00, 8'h00, 1'b0, RES_ZERO},
        // transfer count of one, pushed byte held until the tick
        '{1'b1, 16'h0001, hslp_pkg::CMD_WR_DATA, 8'h00, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_CTRL, 8'hFF, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_TICK,    8'h00, 8'h01, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_PUSHED,  8'h11, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_TICK,    8'h00, 8'h00, 1'b0, RES_ZERO},
        '{1'b1, 16'hFFFF, hslp_pkg::CMD_WR_DATA, 8'h00, 8'h00, 1'b0, RES_ZERO},
        '{1'b0, 16'h0000, hslp_pkg::CMD_WR_CTRL, 8'h81, 8'hFF, 1'b0, RES_ZERO}
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [hslp_pkg::ADDR_W-1:0] paddr;
    logic [hslp_pkg::APB_W-1:0]  pwdata;
    logic [hslp_pkg::APB_W-1:0]  prdata;
    logic                        pready;

    hslp_in_if  cmd_ch ();
    hslp_out_if res_ch ();

    handheld_serial_link_port dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .i_in      (cmd_ch),
        .o_out     (res_ch)
    );

    // port state as the bench sees it
    hslp_pkg::t_mode             lnk_mode;
    logic [hslp_pkg::BYTE_W-1:0] lnk_data;
    logic [hslp_pkg::BYTE_W-1:0] lnk_ctrl;
    logic [hslp_pkg::BYTE_W-1:0] lnk_held;
    logic                        lnk_held_ok;
    logic [15:0]                 lnk_count;
    logic [15:0]                 lnk_cycles;

    hslp_pkg::t_result exp_results [$];
    int                errors      = 0;
    int                items_done  = 0;
    int                idle_cycles = 0;
    int                tx_run      = 0;
    logic              drv_typed;
    hslp_pkg::t_result drv_exp;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void finish_transfer();
        lnk_held_ok = 1'b0;
        lnk_ctrl    = lnk_ctrl & hslp_pkg::CTRL_DONE_MASK;
        lnk_mode    = hslp_pkg::MODE_IDLE;
        lnk_data    = lnk_held;
    endfunction

    function automatic hslp_pkg::t_result link_step(input hslp_pkg::t_item it);
        hslp_pkg::t_result r;
        hslp_pkg::t_mode   nxt;
        r = '0;
        case (it.cmd)
            hslp_pkg::CMD_WR_DATA: begin
                if (it.byte_in != lnk_data && lnk_mode == hslp_pkg::MODE_PRESENT) begin
                    r.link_event = hslp_pkg::EV_PRESENT;
                    r.link_byte  = it.byte_in;
                end
                lnk_data = it.byte_in;
            end
            hslp_pkg::CMD_WR_CTRL: begin
                if (it.byte_in != lnk_ctrl) begin
                    if ((it.byte_in & hslp_pkg::CTRL_START_BIT) == '0) begin
                        nxt = hslp_pkg::MODE_IDLE;
                    end else if ((it.byte_in & hslp_pkg::CTRL_CLOCK_BIT) != '0) begin
                        nxt = hslp_pkg::MODE_XFER;
                    end else begin
                        nxt = hslp_pkg::MODE_PRESENT;
                    end
                    if (nxt != lnk_mode) begin
                        lnk_mode = nxt;
                        if (nxt == hslp_pkg::MODE_PRESENT) begin
                            r.link_event = hslp_pkg::EV_PRESENT;
                            r.link_byte  = lnk_data;
                        end else if (nxt == hslp_pkg::MODE_XFER) begin
                            r.link_event = hslp_pkg::EV_PUSH;
                            r.link_byte  = lnk_data;
                            lnk_count    = lnk_cycles;
                        end
                    end
                end
                lnk_ctrl = it.byte_in;
            end
            hslp_pkg::CMD_PULLED: begin
                lnk_held    = it.byte_in;
                lnk_held_ok = 1'b1;
                if (lnk_mode == hslp_pkg::MODE_XFER && lnk_count == '0) begin
                    finish_transfer();
                    r.irq = 1'b1;
                end
            end
            hslp_pkg::CMD_PUSHED: begin
                lnk_held    = it.byte_in;
                lnk_held_ok = 1'b1;
                if (lnk_mode == hslp_pkg::MODE_PRESENT) begin
                    finish_transfer();
                    r.irq = 1'b1;
                end
            end
            hslp_pkg::CMD_TICK: begin
                if (lnk_mode == hslp_pkg::MODE_XFER) begin
                    if (lnk_count > {8'h00, it.tick_cycles}) begin
                        lnk_count = lnk_count - {8'h00, it.tick_cycles};
                    end else begin
                        lnk_count = '0;
                        if (lnk_held_ok) begin
                            finish_transfer();
                            r.irq = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.data_reg    = lnk_data;
        r.control_reg = lnk_ctrl;
        return r;
    endfunction

    task automatic compare_result(input hslp_pkg::t_result got,
                                  input hslp_pkg::t_result want);
        if (got.data_reg !== want.data_reg) begin
            $error("data_reg: expected %02h, got %02h", want.data_reg, got.data_reg);
            errors++;
        end
        if (got.control_reg !== want.control_reg) begin
            $error("control_reg: expected %02h, got %02h", want.control_reg,
                   got.control_reg);
            errors++;
        end
        if (got.link_event !== want.link_event) begin
            $error("link_event: expected %0d, got %0d", want.link_event, got.link_event);
            errors++;
        end
        if (got.link_byte !== want.link_byte) begin
            $error("link_byte: expected %02h, got %02h", want.link_byte, got.link_byte);
            errors++;
        end
        if (got.irq !== want.irq) begin
            $error("irq: expected %0b, got %0b", want.irq, got.irq);
            errors++;
        end
    endtask

    // beats are predicted when accepted and checked in order
    always @(posedge i_clk) begin
        hslp_pkg::t_item   acc;
        hslp_pkg::t_result got;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.data_reg    = res_ch.data_reg;
                got.control_reg = res_ch.control_reg;
                got.link_event  = hslp_pkg::t_link_ev'(res_ch.link_event);
                got.link_byte   = res_ch.link_byte;
                got.irq         = res_ch.irq;
                if (exp_results.size() == 0) begin
                    $error("result beat with no expectation pending");
                    errors++;
                end else begin
                    compare_result(got, exp_results.pop_front());
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                acc.cmd         = cmd_ch.cmd;
                acc.byte_in     = cmd_ch.byte_in;
                acc.tick_cycles = cmd_ch.tick_cycles;
                got             = link_step(acc);
                exp_results.push_back(drv_typed ? drv_exp : got);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    initial begin
        int rx_on;
        int rx_off;
        rx_on = 0;
        rx_off = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_on == 0 && rx_off == 0) begin
                rx_on  = $urandom_range(1, 30);
                rx_off = ($urandom_range(0, 5) == 0) ? 0 : pick_gap();
            end
            if (rx_on > 0) begin
                rx_on--;
                res_ch.ready <= 1'b1;
            end else begin
                rx_off--;
                res_ch.ready <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [hslp_pkg::CMD_W-1:0] cmd, input logic [7:0] b,
                             input logic [7:0] cyc, input logic typed,
                             input hslp_pkg::t_result exp);
        int gap;
        if (tx_run > 0) begin
            gap = 0;
            tx_run--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 15) == 0) tx_run = $urandom_range(10, 60);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= cmd;
        cmd_ch.byte_in     <= b;
        cmd_ch.tick_cycles <= cyc;
        drv_typed          <= typed;
        drv_exp            <= exp;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        if (cmd <= hslp_pkg::CMD_TICK) items_done++;
    endtask

    task automatic send(input logic [hslp_pkg::CMD_W-1:0] cmd, input logic [7:0] b,
                        input logic [7:0] cyc);
        send_item(cmd, b, cyc, 1'b0, RES_ZERO);
    endtask

    // hold the command side until every result beat is back
    task automatic settle();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [hslp_pkg::APB_W-1:0] wdata,
                              output logic [hslp_pkg::APB_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {hslp_pkg::REG_XFER_CYCLES, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_xfer_cycles(input logic [15:0] v);
        logic [hslp_pkg::APB_W-1:0] rd;
        apb_access(1'b1, {16'h0000, v}, rd);
        lnk_cycles = v;
        apb_access(1'b0, '0, rd);
        if (rd[15:0] !== v) begin
            $error("transfer_cycles readback: expected %04h, got %04h", v, rd[15:0]);
            errors++;
        end
    endtask

    task automatic run_sequence();
        int         kind;
        int         left;
        int         n;
        logic [7:0] v;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            // internally clocked transfer
            if ($urandom_range(0, 1) == 1) send(hslp_pkg::CMD_WR_DATA, any_byte(), any_byte());
            send(hslp_pkg::CMD_WR_CTRL,
                 any_byte() | hslp_pkg::CTRL_START_BIT | hslp_pkg::CTRL_CLOCK_BIT,
                 any_byte());
            if ($urandom_range(0, 3) == 0) send(hslp_pkg::CMD_PULLED, any_byte(), any_byte());
            left = lnk_cycles;
            n = 0;
            while (left > 0 && n < 24) begin
                v = (left > 512) ? 8'($urandom_range(160, 255)) : any_byte();
                send(hslp_pkg::CMD_TICK, any_byte(), v);
                left -= v;
                n++;
            end
            if ($urandom_range(0, 3) == 0) send(hslp_pkg::CMD_TICK, any_byte(), any_byte());
            send(hslp_pkg::CMD_PULLED, any_byte(), any_byte());
        end else if (kind <= 6) begin
            // partner clocked transfer
            send(hslp_pkg::CMD_WR_CTRL,
                 (any_byte() | hslp_pkg::CTRL_START_BIT) & ~hslp_pkg::CTRL_CLOCK_BIT,
                 any_byte());
            n = $urandom_range(0, 3);
            repeat (n) begin
                v = any_byte();
                send(hslp_pkg::CMD_WR_DATA, v, any_byte());
                if ($urandom_range(0, 2) == 0) send(hslp_pkg::CMD_WR_DATA, v, any_byte());
            end
            if ($urandom_range(0, 3) == 0) send(hslp_pkg::CMD_PULLED, any_byte(), any_byte());
            send(hslp_pkg::CMD_PUSHED, any_byte(), any_byte());
        end else if (kind == 7) begin
            send(hslp_pkg::CMD_WR_CTRL, any_byte() & hslp_pkg::CTRL_DONE_MASK, any_byte());
            if ($urandom_range(0, 1) == 1) send(hslp_pkg::CMD_PUSHED, any_byte(), any_byte());
            else send(hslp_pkg::CMD_PULLED, any_byte(), any_byte());
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send(3'($urandom_range(0, 7)), any_byte(), any_byte());
        end
        if ($urandom_range(0, 29) == 0) settle();
    endtask

    initial begin
        logic [15:0] cyc_set;
        int          start;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.cmd         = '0;
        cmd_ch.byte_in     = '0;
        cmd_ch.tick_cycles = '0;
        drv_typed          = 1'b0;
        drv_exp            = RES_ZERO;
        lnk_mode           = hslp_pkg::MODE_IDLE;
        lnk_data           = '0;
        lnk_ctrl           = '0;
        lnk_held           = '0;
        lnk_held_ok        = 1'b0;
        lnk_count          = '0;
        lnk_cycles         = hslp_pkg::XFER_CYCLES_RST;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_TAB[i].is_cfg) begin
                settle();
                set_xfer_cycles(DIR_TAB[i].cfg_val);
            end else begin
                send_item(DIR_TAB[i].cmd, DIR_TAB[i].byte_in, DIR_TAB[i].cyc,
                          DIR_TAB[i].typed, DIR_TAB[i].exp);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: cyc_set = hslp_pkg::XFER_CYCLES_RST;
                1: cyc_set = 16'd1;
                2: cyc_set = 16'hFFFF;
                3: cyc_set = 16'd0;
                4: cyc_set = 16'($urandom_range(2, 400));
                default: cyc_set = 16'($urandom_range(1, 65535));
            endcase
            settle();
            set_xfer_cycles(cyc_set);
            start = items_done;
            while (items_done - start < PHASE_ITEMS) run_sequence();
        end

        settle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
